FILE: design/packed_fsa_arc_decoder_defines.svh
// Assertion macros used by the checker of the packed arc decoder.
`ifndef PACKED_FSA_ARC_DECODER_DEFINES_SVH
`define PACKED_FSA_ARC_DECODER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PFAD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define PFAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: design/pfad_pkg.sv
// Shared types and constants of the packed arc decoder.
package pfad_pkg;

  localparam int WEIGHT_BYTES_DEF = 4;
  localparam int MAX_FIELD_BYTES  = 4;
  localparam int WORD_W           = 32;
  localparam int BYTE_W           = 8;
  localparam int IN_TDATA_W       = 40;
  localparam int OUT_TDATA_W      = 168;
  localparam int CFG_IDX_W        = 2;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [BYTE_W-1:0] PART_END_MASK = 8'h1c;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEPTOR   = 2'd0,
    CFG_EPSILON    = 2'd1,
    CFG_WEIGHT_ONE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_ARC    = 2'd1,
    KIND_END    = 2'd2,
    KIND_BAD    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FINAL  = 3'd1,
    PH_PART   = 3'd2,
    PH_TARGET = 3'd3,
    PH_WEIGHT = 3'd4,
    PH_IN     = 3'd5,
    PH_OUT    = 3'd6
  } phase_e;

  typedef struct packed {
    logic              acceptor;
    logic [WORD_W-1:0] epsilon;
    logic [WORD_W-1:0] weight_one;
  } cfg_t;

  // One parsed record entry as it travels from the parser to the formatter.
  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] state_tag;
    logic [2:0]        tags;
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] weight;
    logic [WORD_W-1:0] in_label;
    logic [WORD_W-1:0] out_label;
    logic              wt_stored;
    logic              in_stored;
    logic              out_stored;
  } event_t;

endpackage

FILE: design/packed_fsa_arc_decoder.sv
// Top level of the byte-serial packed automaton state record decoder.
// The decoder takes one record byte per clock cycle and gives at most one
// result word per byte; a byte's result passes through the event queue and
// then the output register to the master side. The rate is set by the parser
// loop, which updates its phase, byte counter and field accumulators with
// each byte. While the master side stalls, the output register and a
// two-word event queue hold up to three results; once the queue is full
// s_axis_tready drops until a word is taken. A header byte (tuser high)
// restarts parsing at any point. The acceptor flag is applied as each byte
// is parsed and, with the epsilon label and weight one, as each word is
// formatted, so write configuration only while no byte or word is in flight.
module packed_fsa_arc_decoder #(
  parameter int WEIGHT_BYTES = pfad_pkg::WEIGHT_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] data_byte, [39:8] state_number
  input  logic [pfad_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] header_flag
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] state_tag, [34:32] tags, [66:35] target, [98:67] weight,
  // [130:99] input_label, [162:131] output_label, [167:163] zero
  output logic [pfad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]                       m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we_i,
  input  logic [pfad_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pfad_pkg::WORD_W-1:0]      cfg_data_i
);
  import pfad_pkg::*;

  cfg_t   cfg_q;
  logic   take;
  logic   push, q_ready, q_valid, pop;
  event_t ev_in, ev_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACCEPTOR:   cfg_q.acceptor   <= cfg_data_i[0];
        CFG_EPSILON:    cfg_q.epsilon    <= cfg_data_i;
        CFG_WEIGHT_ONE: cfg_q.weight_one <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = q_ready;
  assign take          = s_axis_tvalid && q_ready;

  pfad_front #(
    .WEIGHT_BYTES(WEIGHT_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .byte_i     (s_axis_tdata[BYTE_W-1:0]),
    .header_i   (s_axis_tuser),
    .state_i    (s_axis_tdata[BYTE_W +: WORD_W]),
    .acceptor_i (cfg_q.acceptor),
    .push_o     (push),
    .ev_o       (ev_in)
  );

  pfad_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ev_i    (ev_in),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .ev_o    (ev_out)
  );

  pfad_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .ev_i      (ev_out),
    .pop_o     (pop),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata),
    .m_kind_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule

FILE: design/pfad_front.sv
// Byte parser: walks the state record and emits raw header, arc, end and malformed events.
module pfad_front #(
  parameter int WEIGHT_BYTES = pfad_pkg::WEIGHT_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic [pfad_pkg::BYTE_W-1:0]   byte_i,
  input  logic                          header_i,
  input  logic [pfad_pkg::WORD_W-1:0]   state_i,
  input  logic                          acceptor_i,
  output logic                          push_o,
  output pfad_pkg::event_t              ev_o
);
  import pfad_pkg::*;

  localparam int CNT_W = ($clog2(WEIGHT_BYTES + 1) > 3) ? $clog2(WEIGHT_BYTES + 1) : 3;
  localparam logic [CNT_W-1:0] WB = CNT_W'(WEIGHT_BYTES);

  function automatic logic [WORD_W-1:0] gather(input logic [WORD_W-1:0] acc,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [CNT_W-1:0]  idx);
    logic [WORD_W-1:0] r;
    r = acc;
    if (idx < CNT_W'(MAX_FIELD_BYTES)) begin
      r[BYTE_W*idx[1:0] +: BYTE_W] = b;
    end
    return r;
  endfunction

  // Output label byte count: io / 5 for a five-bit io code.
  function automatic logic [2:0] out_count(input logic [4:0] io);
    logic [2:0] n;
    if (io >= 5'd30) n = 3'd6;
    else if (io >= 5'd25) n = 3'd5;
    else if (io >= 5'd20) n = 3'd4;
    else if (io >= 5'd15) n = 3'd3;
    else if (io >= 5'd10) n = 3'd2;
    else if (io >= 5'd5) n = 3'd1;
    else n = 3'd0;
    return n;
  endfunction

  function automatic logic [2:0] in_count(input logic [4:0] io);
    logic [4:0] prod;
    logic [4:0] rem;
    prod = 5'({2'b00, out_count(io)} * 5);
    rem  = io - prod;
    return rem[2:0];
  endfunction

  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] part_q, part_d;
  logic [WORD_W-1:0] target_q, target_d;
  logic [WORD_W-1:0] weight_q, weight_d;
  logic [WORD_W-1:0] inl_q, inl_d;
  logic [WORD_W-1:0] outl_q, outl_d;
  logic [WORD_W-1:0] cur_q, cur_d;

  logic [2:0]       in_n, out_n;
  logic             out_has;
  logic [CNT_W-1:0] cnt_inc, field_len;
  logic             end_byte, bad_byte, final_done, field_done;
  phase_e           nxt_field;

  assign in_n       = in_count(part_q[4:0]);
  assign out_n      = out_count(part_q[4:0]);
  assign out_has    = !acceptor_i && (out_n != 3'd0);
  assign cnt_inc    = cnt_q + 1'b1;
  assign end_byte   = (byte_i & PART_END_MASK) == PART_END_MASK;
  assign bad_byte   = !acceptor_i && (out_count(byte_i[4:0]) > 3'(MAX_FIELD_BYTES));
  assign final_done = (cnt_inc == WB);
  assign field_done = !(cnt_inc < field_len);

  always_comb begin
    case (phase_q)
      PH_TARGET: field_len = CNT_W'({1'b0, part_q[7:6]}) + 1'b1;
      PH_WEIGHT: field_len = part_q[5] ? WB : '0;
      PH_IN:     field_len = CNT_W'(in_n);
      PH_OUT:    field_len = out_has ? CNT_W'(out_n) : '0;
      default:   field_len = '0;
    endcase
  end

  // Skip the fields of this arc that carry no bytes.
  always_comb begin
    case (phase_q)
      PH_TARGET: begin
        if (part_q[5]) nxt_field = PH_WEIGHT;
        else if (in_n != 3'd0) nxt_field = PH_IN;
        else if (out_has) nxt_field = PH_OUT;
        else nxt_field = PH_PART;
      end
      PH_WEIGHT: begin
        if (in_n != 3'd0) nxt_field = PH_IN;
        else if (out_has) nxt_field = PH_OUT;
        else nxt_field = PH_PART;
      end
      PH_IN: begin
        if (out_has) nxt_field = PH_OUT;
        else nxt_field = PH_PART;
      end
      default: nxt_field = PH_PART;
    endcase
  end

  // Next state
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    part_d   = part_q;
    target_d = target_q;
    weight_d = weight_q;
    inl_d    = inl_q;
    outl_d   = outl_q;
    cur_d    = cur_q;
    if (take_i) begin
      if (header_i) begin
        cur_d    = state_i;
        part_d   = byte_i;
        cnt_d    = '0;
        weight_d = '0;
        phase_d  = byte_i[0] ? PH_FINAL : PH_PART;
      end else begin
        case (phase_q)
          PH_FINAL: begin
            weight_d = gather(weight_q, byte_i, cnt_q);
            if (final_done) begin
              cnt_d   = '0;
              phase_d = PH_PART;
            end else begin
              cnt_d = cnt_inc;
            end
          end
          PH_PART: begin
            cnt_d = '0;
            if (end_byte) begin
              phase_d = PH_IDLE;
            end else begin
              part_d = byte_i;
              if (bad_byte) begin
                phase_d = PH_IDLE;
              end else begin
                target_d = '0;
                weight_d = '0;
                inl_d    = '0;
                outl_d   = '0;
                phase_d  = PH_TARGET;
              end
            end
          end
          PH_TARGET, PH_WEIGHT, PH_IN, PH_OUT: begin
            if (phase_q == PH_TARGET) target_d = gather(target_q, byte_i, cnt_q);
            else if (phase_q == PH_WEIGHT) weight_d = gather(weight_q, byte_i, cnt_q);
            else if (phase_q == PH_IN) inl_d = gather(inl_q, byte_i, cnt_q);
            else outl_d = gather(outl_q, byte_i, cnt_q);
            if (field_done) begin
              cnt_d   = '0;
              phase_d = nxt_field;
            end else begin
              cnt_d = cnt_inc;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Outputs
  always_comb begin
    push_o          = 1'b0;
    ev_o.kind       = KIND_HEADER;
    ev_o.state_tag  = cur_d;
    ev_o.tags       = '0;
    ev_o.target     = target_d;
    ev_o.weight     = weight_d;
    ev_o.in_label   = inl_d;
    ev_o.out_label  = outl_d;
    ev_o.wt_stored  = 1'b0;
    ev_o.in_stored  = 1'b0;
    ev_o.out_stored = 1'b0;
    if (take_i) begin
      if (header_i) begin
        if (!byte_i[0]) begin
          push_o    = 1'b1;
          ev_o.tags = byte_i[7:5];
        end
      end else begin
        case (phase_q)
          PH_FINAL: begin
            if (final_done) begin
              push_o         = 1'b1;
              ev_o.tags      = part_q[7:5];
              ev_o.wt_stored = 1'b1;
            end
          end
          PH_PART: begin
            if (end_byte) begin
              push_o    = 1'b1;
              ev_o.kind = KIND_END;
            end else if (bad_byte) begin
              push_o    = 1'b1;
              ev_o.kind = KIND_BAD;
            end
          end
          PH_TARGET, PH_WEIGHT, PH_IN, PH_OUT: begin
            if (field_done && (nxt_field == PH_PART)) begin
              push_o          = 1'b1;
              ev_o.kind       = KIND_ARC;
              ev_o.wt_stored  = part_q[5];
              ev_o.in_stored  = (in_n != 3'd0);
              ev_o.out_stored = (out_n != 3'd0);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      part_q   <= '0;
      target_q <= '0;
      weight_q <= '0;
      inl_q    <= '0;
      outl_q   <= '0;
      cur_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      part_q   <= part_d;
      target_q <= target_d;
      weight_q <= weight_d;
      inl_q    <= inl_d;
      outl_q   <= outl_d;
      cur_q    <= cur_d;
    end
  end

endmodule

FILE: design/pfad_queue.sv
// Short event queue between the parser and the result formatter.
module pfad_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pfad_pkg::event_t ev_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output pfad_pkg::event_t ev_o
);
  import pfad_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  event_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign ready_o = (count_q != FULL_CNT);
  assign valid_o = (count_q != '0);
  assign ev_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: design/pfad_back.sv
// Result formatter: fills in defaults, zeroes unused fields and holds the output word.
module pfad_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pfad_pkg::cfg_t                   cfg_i,
  input  logic                             q_valid_i,
  input  pfad_pkg::event_t                 ev_i,
  output logic                             pop_o,
  input  logic                             m_ready_i,
  output logic                             m_valid_o,
  output logic [pfad_pkg::OUT_TDATA_W-1:0] m_data_o,
  output logic [1:0]                       m_kind_o,
  output logic                             m_last_o
);
  import pfad_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - (5 * WORD_W + 3);

  logic [2:0]        tags;
  logic [WORD_W-1:0] target, weight, inl, outl;
  logic              last;

  logic                   valid_q;
  logic [OUT_TDATA_W-1:0] data_q;
  logic [1:0]             kind_q;
  logic                   last_q;

  // Take the next word whenever the output register is empty or being drained.
  assign pop_o = q_valid_i && (!valid_q || m_ready_i);

  always_comb begin
    tags   = '0;
    target = '0;
    weight = '0;
    inl    = '0;
    outl   = '0;
    last   = 1'b0;
    case (ev_i.kind)
      KIND_HEADER: begin
        tags   = ev_i.tags;
        weight = ev_i.wt_stored ? ev_i.weight : cfg_i.weight_one;
      end
      KIND_ARC: begin
        target = ev_i.target;
        weight = ev_i.wt_stored ? ev_i.weight : cfg_i.weight_one;
        inl    = ev_i.in_stored ? ev_i.in_label : cfg_i.epsilon;
        if (cfg_i.acceptor) outl = inl;
        else outl = ev_i.out_stored ? ev_i.out_label : cfg_i.epsilon;
      end
      KIND_END, KIND_BAD: begin
        last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= {{PAD_W{1'b0}}, outl, inl, weight, target, tags, ev_i.state_tag};
      kind_q <= ev_i.kind;
      last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_kind_o  = kind_q;
  assign m_last_o  = last_q;

endmodule

FILE: design/pfad_checker.sv
// Port-level checker of the packed arc decoder and its bind.
`include "packed_fsa_arc_decoder_defines.svh"

module pfad_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [pfad_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pfad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                       m_axis_tuser,
  input logic                             m_axis_tlast,
  input logic                             cfg_we_i,
  input logic [pfad_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input logic [pfad_pkg::WORD_W-1:0]      cfg_data_i
);
  import pfad_pkg::*;

  logic is_stop, is_arc, arc_fields_zero;

  assign is_stop = (m_axis_tuser == KIND_END) || (m_axis_tuser == KIND_BAD);
  assign is_arc  = (m_axis_tuser == KIND_ARC);
  assign arc_fields_zero = (m_axis_tdata[66:35] == '0) && (m_axis_tdata[162:99] == '0);

  `PFAD_ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "result word during reset")
  `PFAD_ASSERT(a_hold_stalled_word, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result word changed")
  `PFAD_ASSERT(a_last_on_stop, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tlast == is_stop), "tlast does not match end or malformed kind")
  `PFAD_ASSERT(a_non_arc_zero, clk_i, rst_ni, m_axis_tvalid && !is_arc |-> arc_fields_zero, "non-arc word carries target or labels")

endmodule

bind packed_fsa_arc_decoder pfad_checker u_pfad_checker (.*);
